[rtl/crp_pkg.sv]
// ----------------------------------------------------------------------------
// crp_pkg
// Shared widths and constants for the Chinese restaurant process table sampler.
// ----------------------------------------------------------------------------
package crp_pkg;

  localparam int MAX_TABLES = 64;

  // Storage and counter widths.
  localparam int ADDR_W    = $clog2(MAX_TABLES);
  localparam int CNT_W     = $clog2(MAX_TABLES + 1);
  localparam int OCC_W     = 16;
  localparam int CUST_W    = 16;
  localparam int ALPHA_W   = 16;
  localparam int DRAW_W    = 16;

  // Total weight is customers*256 + alpha, one bit of headroom for the add.
  localparam int TOT_W     = CUST_W + 8 + 1;
  localparam int TGT_W     = TOT_W;
  // Running sum of occupancies, compared after scaling by 256.
  localparam int SUM_W     = TGT_W - 8;

  // Result field widths.
  localparam int OUT_IDX_W = 7;

  localparam logic [ALPHA_W-1:0] ALPHA_RESET = ALPHA_W'(256);
  localparam logic [CUST_W-1:0]  CUST_FULL   = {CUST_W{1'b1}};

  // Input command codes.
  localparam logic CMD_START = 1'b0;
  localparam logic CMD_SEAT  = 1'b1;

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_TGT  = 4'b0010,
    S_WALK = 4'b0100,
    S_UPD  = 4'b1000
  } state_t;

endpackage

[rtl/crp_ram.sv]
// ----------------------------------------------------------------------------
// crp_ram
// Generic single-clock RAM: one write port, one read port, registered read.
// ----------------------------------------------------------------------------
module crp_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

[rtl/crp_target.sv]
// ----------------------------------------------------------------------------
// crp_target
// Two-stage computation of the seating target from the draw and total weight.
// ----------------------------------------------------------------------------
module crp_target
  import crp_pkg::*;
(
  input  logic               clk,
  input  logic               load,
  input  logic [DRAW_W-1:0]  draw,
  input  logic [CUST_W-1:0]  customer_total,
  input  logic [ALPHA_W-1:0] alpha,
  output logic [TGT_W-1:0]   target
);

  logic [DRAW_W-1:0]        draw_r;
  logic [TOT_W-1:0]         total_r;
  logic [TGT_W-1:0]         target_r;
  logic [DRAW_W+TOT_W-1:0]  product;

  // Stage one: total weight, captured with the draw when a word is taken.
  always_ff @(posedge clk) begin
    if (load) begin
      draw_r  <= draw;
      total_r <= {1'b0, customer_total, 8'b0} + TOT_W'(alpha);
    end
  end

  // Stage two: scale the draw, keep the integer part.
  assign product = (DRAW_W+TOT_W)'(draw_r) * (DRAW_W+TOT_W)'(total_r);

  always_ff @(posedge clk) begin
    target_r <= product[DRAW_W +: TGT_W];
  end

  assign target = target_r;

endmodule

[rtl/crp_table_sampler.sv]
// ----------------------------------------------------------------------------
// crp_table_sampler
// Chinese restaurant process seating over an occupancy RAM of MAX_TABLES.
// ----------------------------------------------------------------------------
// Flow: a start word goes from idle straight to the update state; a seat
// word passes the target, scan and update states, and the scan reads the
// occupancy RAM one table per cycle through its single read port. One word is
// taken at a time; its result is registered once the output slot is free.
// Reset: synchronous, active low; clears the table and customer counts and
// sets alpha to 1.0. The RAM is not cleared: only open tables are ever read.
module crp_table_sampler
  import crp_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,

  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [15:0] in_tdata,   // [15:0] draw
  input  logic        in_tuser,   // [0] command

  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [31:0] out_tdata,  // [6:0] table_index, [22:7] table_occupancy,
                                  // [29:23] tables_open, [31:30] zero
  output logic [1:0]  out_tuser,  // [0] new_table, [1] rejected

  input  logic        cfg_wr_en,
  input  logic [15:0] cfg_wr_data
);

  state_t             state_r, state_nxt;
  logic [ALPHA_W-1:0] alpha_r;
  logic [CNT_W-1:0]   open_r;
  logic [CUST_W-1:0]  cust_r;

  logic [CNT_W-1:0]   rd_idx_r;
  logic               pend_r;
  logic [CNT_W-1:0]   pend_idx_r;
  logic [SUM_W-1:0]   sum_r;
  logic [CNT_W-1:0]   chosen_r;
  logic [OCC_W-1:0]   occ_r;
  logic               new_r;
  logic               start_r;

  logic               out_valid_r;
  logic [OUT_IDX_W-1:0] out_idx_r;
  logic [OCC_W-1:0]   out_occ_r;
  logic [OUT_IDX_W-1:0] out_open_r;
  logic               out_new_r;
  logic               out_rej_r;

  logic               accept;
  logic [TGT_W-1:0]   target;
  logic [SUM_W-1:0]   sum_add;
  logic               hit;
  logic               issue;
  logic               scan_end;
  logic               upd_fire;
  logic               reject;
  logic [OCC_W-1:0]   rd_data;
  logic               wr_en;
  logic [ADDR_W-1:0]  wr_addr;
  logic [OCC_W-1:0]   wr_data;

  assign accept    = in_tvalid && in_tready;
  assign in_tready = (state_r == S_IDLE);

  crp_target u_target (
    .clk            (clk),
    .load           (accept),
    .draw           (in_tdata[DRAW_W-1:0]),
    .customer_total (cust_r),
    .alpha          (alpha_r),
    .target         (target)
  );

  // The scan only reads, and the single write lands in the update cycle
  // before the next word can be taken, so reads never race a write.
  crp_ram #(
    .WIDTH (OCC_W),
    .DEPTH (MAX_TABLES)
  ) u_occ_ram (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_en   (issue),
    .rd_addr (rd_idx_r[ADDR_W-1:0]),
    .rd_data (rd_data)
  );

  // Scan: one read issued per cycle, its data summed the cycle after.
  assign sum_add  = sum_r + SUM_W'(rd_data);
  assign hit      = (state_r == S_WALK) && pend_r && ({sum_add, 8'b0} > target);
  assign issue    = (state_r == S_WALK) && !hit && (rd_idx_r < open_r);
  assign scan_end = (state_r == S_WALK) && !pend_r && (rd_idx_r >= open_r);

  assign upd_fire = (state_r == S_UPD) && (!out_valid_r || out_tready);
  assign reject   = !start_r &&
                    ((cust_r == CUST_FULL) ||
                     (new_r && (open_r >= CNT_W'(MAX_TABLES))));

  always_comb begin
    wr_en   = upd_fire && !reject;
    wr_addr = start_r ? '0 : chosen_r[ADDR_W-1:0];
    wr_data = (start_r || new_r) ? OCC_W'(1) : occ_r + OCC_W'(1);
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (accept) begin
          state_nxt = (in_tuser == CMD_START) ? S_UPD : S_TGT;
        end
      end
      S_TGT:  state_nxt = S_WALK;
      S_WALK: begin
        if (hit || scan_end) begin
          state_nxt = S_UPD;
        end
      end
      S_UPD: begin
        if (upd_fire) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      alpha_r     <= ALPHA_RESET;
      open_r      <= '0;
      cust_r      <= '0;
      pend_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (cfg_wr_en) begin
        alpha_r <= cfg_wr_data;
      end
      pend_r <= issue;
      if (upd_fire && !reject) begin
        if (start_r) begin
          open_r <= CNT_W'(1);
          cust_r <= CUST_W'(1);
        end else begin
          if (new_r) begin
            open_r <= open_r + CNT_W'(1);
          end
          cust_r <= cust_r + CUST_W'(1);
        end
      end
      if (upd_fire) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Scan and result payload.
  always_ff @(posedge clk) begin
    if (accept) begin
      start_r  <= (in_tuser == CMD_START);
      rd_idx_r <= '0;
      sum_r    <= '0;
    end
    if (issue) begin
      rd_idx_r   <= rd_idx_r + CNT_W'(1);
      pend_idx_r <= rd_idx_r;
    end
    if (pend_r && (state_r == S_WALK)) begin
      sum_r <= sum_add;
    end
    if (hit) begin
      chosen_r <= pend_idx_r;
      occ_r    <= rd_data;
      new_r    <= 1'b0;
    end else if (scan_end) begin
      chosen_r <= open_r;
      new_r    <= 1'b1;
    end
    if (upd_fire) begin
      if (start_r) begin
        out_idx_r  <= OUT_IDX_W'(1);
        out_new_r  <= 1'b1;
        out_occ_r  <= OCC_W'(1);
        out_open_r <= OUT_IDX_W'(1);
        out_rej_r  <= 1'b0;
      end else if (reject) begin
        out_idx_r  <= '0;
        out_new_r  <= 1'b0;
        out_occ_r  <= '0;
        out_open_r <= OUT_IDX_W'(open_r);
        out_rej_r  <= 1'b1;
      end else begin
        out_idx_r  <= OUT_IDX_W'(chosen_r + CNT_W'(1));
        out_new_r  <= new_r;
        out_occ_r  <= wr_data;
        out_open_r <= new_r ? OUT_IDX_W'(open_r + CNT_W'(1)) : OUT_IDX_W'(open_r);
        out_rej_r  <= 1'b0;
      end
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {2'b00, out_open_r, out_occ_r, out_idx_r};
  assign out_tuser  = {out_rej_r, out_new_r};

endmodule

[verif/crp_table_sampler_checker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// crp_table_sampler_checker
// Watches the input, result and configuration ports of the table sampler,
// keeps its own copy of the seating state, predicts every result word and
// compares it field by field with what the block returns.
// ----------------------------------------------------------------------------
module crp_table_sampler_checker
  import crp_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  input  logic        in_tready,
  input  logic [15:0] in_tdata,   // [15:0] draw
  input  logic        in_tuser,   // [0] command
  input  logic        out_tvalid,
  input  logic        out_tready,
  input  logic [31:0] out_tdata,  // [6:0] table_index, [22:7] table_occupancy,
                                  // [29:23] tables_open, [31:30] zero
  input  logic [1:0]  out_tuser,  // [0] new_table, [1] rejected
  input  logic        cfg_wr_en,
  input  logic [15:0] cfg_wr_data,
  output int          mismatches,
  output int          seatings_pending,
  output int          rejections_seen
);

  typedef struct packed {
    logic [OUT_IDX_W-1:0] table_index;
    logic                 new_table;
    logic [OCC_W-1:0]     occupancy;
    logic [OUT_IDX_W-1:0] tables_open;
    logic                 rejected;
  } seating_t;

  logic [ALPHA_W-1:0] alpha;
  logic [OCC_W-1:0]   table_occ [MAX_TABLES];
  int                 tables_in_use;
  logic [CUST_W-1:0]  customers;
  seating_t           seating_q [$];

  initial begin
    mismatches       = 0;
    seatings_pending = 0;
    rejections_seen  = 0;
  end

  // Seats one customer (or restarts the process) and returns the result word.
  function automatic seating_t seat_customer(input logic cmd,
                                             input logic [DRAW_W-1:0] draw);
    seating_t    res;
    logic [31:0] weight_total;
    logic [47:0] target;
    logic [47:0] run_sum;
    int          pick;
    res = '0;
    if (cmd == CMD_START) begin
      foreach (table_occ[t]) table_occ[t] = '0;
      table_occ[0]      = OCC_W'(1);
      tables_in_use     = 1;
      customers         = CUST_W'(1);
      res.table_index   = OUT_IDX_W'(1);
      res.new_table     = 1'b1;
      res.occupancy     = OCC_W'(1);
    end else begin
      weight_total = 32'(customers) * 256 + 32'(alpha);
      target       = (48'(draw) * 48'(weight_total)) >> 16;
      run_sum      = '0;
      pick         = tables_in_use;
      // The first table whose running weight passes the target takes the customer.
      for (int t = 0; t < tables_in_use; t++) begin
        run_sum = run_sum + 48'(table_occ[t]) * 256;
        if (pick == tables_in_use && run_sum > target) pick = t;
      end
      if (customers == CUST_FULL ||
          (pick == tables_in_use && tables_in_use >= MAX_TABLES)) begin
        res.rejected = 1'b1;
      end else if (pick == tables_in_use) begin
        table_occ[pick] = OCC_W'(1);
        tables_in_use   = tables_in_use + 1;
        customers       = customers + CUST_W'(1);
        res.table_index = OUT_IDX_W'(pick + 1);
        res.new_table   = 1'b1;
        res.occupancy   = OCC_W'(1);
      end else begin
        table_occ[pick] = table_occ[pick] + OCC_W'(1);
        customers       = customers + CUST_W'(1);
        res.table_index = OUT_IDX_W'(pick + 1);
        res.occupancy   = table_occ[pick];
      end
    end
    res.tables_open = OUT_IDX_W'(tables_in_use);
    return res;
  endfunction

  task automatic report_error(input string field, input logic [31:0] got,
                              input logic [31:0] want);
    $display("ERROR %0t: %s got 0x%0h, expected 0x%0h", $time, field, got, want);
    mismatches++;
  endtask

  always @(posedge clk) begin
    seating_t got;
    seating_t want;
    seating_t pred;
    int       delta;
    if (!rst_n) begin
      alpha         = ALPHA_RESET;
      tables_in_use = 0;
      customers     = '0;
      seating_q.delete();
      seatings_pending <= 0;
    end else begin
      delta = 0;
      if (cfg_wr_en) alpha = cfg_wr_data;
      if (out_tvalid && out_tready) begin
        got.table_index = out_tdata[6:0];
        got.occupancy   = out_tdata[22:7];
        got.tables_open = out_tdata[29:23];
        got.new_table   = out_tuser[0];
        got.rejected    = out_tuser[1];
        if (got.rejected === 1'b1) rejections_seen++;
        if (seating_q.size() == 0) begin
          report_error("result word with nothing pending", out_tdata, '0);
        end else begin
          want  = seating_q.pop_front();
          delta = delta - 1;
          if (got.table_index !== want.table_index)
            report_error("table_index", 32'(got.table_index), 32'(want.table_index));
          if (got.new_table !== want.new_table)
            report_error("new_table", 32'(got.new_table), 32'(want.new_table));
          if (got.occupancy !== want.occupancy)
            report_error("table_occupancy", 32'(got.occupancy), 32'(want.occupancy));
          if (got.tables_open !== want.tables_open)
            report_error("tables_open", 32'(got.tables_open), 32'(want.tables_open));
          if (got.rejected !== want.rejected)
            report_error("rejected", 32'(got.rejected), 32'(want.rejected));
        end
      end
      if (in_tvalid && in_tready) begin
        pred      = seat_customer(in_tuser, in_tdata);
        seating_q = {seating_q, pred};
        delta     = delta + 1;
      end
      seatings_pending <= seatings_pending + delta;
    end
  end

endmodule

[verif/tb_crp_table_sampler.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_crp_table_sampler
// Drives seating and start words into the table sampler with random gaps and
// result back-pressure, sweeps alpha through its extremes, fills the table
// store and reports the checker's verdict.
// ----------------------------------------------------------------------------
module tb_crp_table_sampler;
  import crp_pkg::*;

  localparam int STALL_LIMIT = 5000;
  localparam int WORD_TARGET = 1000;

  logic        clk         = 1'b0;
  logic        rst_n       = 1'b0;
  logic        in_tvalid   = 1'b0;
  logic        in_tready;
  logic [15:0] in_tdata    = '0;   // [15:0] draw
  logic        in_tuser    = 1'b0; // [0] command
  logic        out_tvalid;
  logic        out_tready  = 1'b0;
  logic [31:0] out_tdata;          // [6:0] table_index, [22:7] table_occupancy,
                                   // [29:23] tables_open, [31:30] zero
  logic [1:0]  out_tuser;          // [0] new_table, [1] rejected
  logic        cfg_wr_en   = 1'b0;
  logic [15:0] cfg_wr_data = '0;

  int mismatches;
  int seatings_pending;
  int rejections_seen;
  bit steady       = 1'b0;  // no idling on either side while set
  int quiet_cycles = 0;
  int words_sent   = 0;
  int alpha_writes = 0;
  int episodes     = 0;

  crp_table_sampler dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),
    .in_tuser    (in_tuser),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),
    .out_tuser   (out_tuser),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data)
  );

  crp_table_sampler_checker seating_checker (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_tvalid        (in_tvalid),
    .in_tready        (in_tready),
    .in_tdata         (in_tdata),
    .in_tuser         (in_tuser),
    .out_tvalid       (out_tvalid),
    .out_tready       (out_tready),
    .out_tdata        (out_tdata),
    .out_tuser        (out_tuser),
    .cfg_wr_en        (cfg_wr_en),
    .cfg_wr_data      (cfg_wr_data),
    .mismatches       (mismatches),
    .seatings_pending (seatings_pending),
    .rejections_seen  (rejections_seen)
  );

  initial begin
    forever #6 clk = ~clk;
  end

  always @(posedge clk) begin
    out_tready <= steady || ($urandom_range(0, 99) >= 10);
  end

  // Ends the run when no word moves on either side for too long.
  always @(posedge clk) begin
    if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= STALL_LIMIT) begin
      $display("crp_table_sampler: mismatch");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  task automatic send_word(input logic cmd, input logic [15:0] draw);
    if (!steady && $urandom_range(0, 99) < 10) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 72)) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= cmd;
    in_tdata  <= draw;
    do @(posedge clk); while (!in_tready);
    words_sent++;
  endtask

  task automatic wait_all_seated();
    in_tvalid <= 1'b0;
    do @(posedge clk); while (seatings_pending != 0);
  endtask

  task automatic set_alpha(input logic [15:0] value);
    wait_all_seated();
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= value;
    @(posedge clk);
    cfg_wr_en   <= 1'b0;
    alpha_writes++;
  endtask

  function automatic logic [15:0] pick_draw(input bit high_only);
    if (high_only) return 16'($urandom_range(16'hF000, 16'hFFFF));
    case ($urandom_range(0, 15))
      0:       return 16'h0000;
      1:       return 16'hFFFF;
      default: return 16'($urandom);
    endcase
  endfunction

  initial begin
    int          ep_len;
    bit          fill;
    logic        cmd;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    // Zero alpha with no customers yet: the only way a seat opens a table.
    set_alpha(16'h0000);
    send_word(CMD_SEAT, 16'h0000);
    send_word(CMD_SEAT, 16'hFFFF);
    send_word(CMD_START, 16'hFFFF);
    send_word(CMD_START, 16'h1234);
    send_word(CMD_SEAT, 16'h0000);
    send_word(CMD_SEAT, 16'hFFFF);
    set_alpha(16'hFFFF);
    send_word(CMD_START, 16'h0000);
    send_word(CMD_SEAT, 16'hFFFF);
    send_word(CMD_SEAT, 16'h0000);
    send_word(CMD_SEAT, 16'h8000);
    send_word(CMD_SEAT, 16'hFFFF);
    send_word(CMD_SEAT, 16'hFFFF);
    set_alpha(16'h0100);
    send_word(CMD_SEAT, 16'h8000);
    send_word(CMD_SEAT, 16'hFFFF);
    send_word(CMD_SEAT, 16'h0001);
    send_word(CMD_START, 16'h8000);

    // A long run with no idling; with zero alpha everyone sits at table 1.
    steady <= 1'b1;
    set_alpha(16'h0000);
    send_word(CMD_START, 16'($urandom));
    repeat (200) send_word(CMD_SEAT, 16'($urandom));
    repeat (3) send_word(CMD_SEAT, pick_draw(1'b0));
    set_alpha(16'hFFFF);
    send_word(CMD_SEAT, 16'hFFFF);
    send_word(CMD_SEAT, 16'h0000);
    steady <= 1'b0;

    while (words_sent < WORD_TARGET) begin
      // Fill episodes use a heavy alpha and high draws to run out of tables.
      fill = (episodes == 0) || ($urandom_range(0, 4) == 0);
      if (fill) begin
        set_alpha(16'($urandom_range(16'hC000, 16'hFFFF)));
      end else if ($urandom_range(0, 1) == 0) begin
        case ($urandom_range(0, 4))
          0:       set_alpha(16'h0000);
          1:       set_alpha(16'hFFFF);
          2:       set_alpha(16'($urandom_range(1, 255)));
          3:       set_alpha(16'h0100);
          default: set_alpha(16'($urandom));
        endcase
      end else if ($urandom_range(0, 7) == 0) begin
        wait_all_seated();
      end
      if ($urandom_range(0, 7) != 0) send_word(CMD_START, 16'($urandom));
      ep_len = fill ? $urandom_range(66, 90) : $urandom_range(1, 40);
      repeat (ep_len) begin
        cmd = (!fill && $urandom_range(0, 19) == 0) ? CMD_START : CMD_SEAT;
        send_word(cmd, pick_draw(fill));
      end
      episodes++;
    end

    wait_all_seated();
    repeat (80) @(posedge clk);
    $display("Sent %0d words (%0d random episodes) with %0d alpha writes from 0 to 0xFFFF.",
             words_sent, episodes, alpha_writes);
    $display("Drove the table store full; %0d seatings refused.", rejections_seen);
    if (mismatches == 0) begin
      $display("crp_table_sampler: match");
    end else begin
      $display("crp_table_sampler: mismatch");
    end
    $finish;
  end

endmodule

[filelist.f]
rtl/crp_pkg.sv
rtl/crp_ram.sv
rtl/crp_target.sv
rtl/crp_table_sampler.sv
verif/crp_table_sampler_checker.sv
verif/tb_crp_table_sampler.sv
